>>> design/cmwc_pkg.sv
// ----------------------------------------------------------------------------
// cmwc_pkg
// Shared types and constants of the CMWC4096 random word generator.
// ----------------------------------------------------------------------------
package cmwc_pkg;

	localparam int TABLE_DEPTH = 4096;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int WORD_W      = 32;
	localparam int CARRY_W     = 19;
	localparam int MUL_W       = 15;
	localparam int PROD_W      = WORD_W + MUL_W;
	localparam int SUM_W       = PROD_W + 1;
	localparam int CHI_W       = SUM_W - WORD_W;

	localparam logic [WORD_W-1:0]  PHI_WORD        = 32'h9e37_79b9;
	localparam logic [WORD_W-1:0]  PHI_WORD_X2     = 32'h3c6e_f372;
	localparam logic [CARRY_W-1:0] CARRY_RESET     = 19'd362436;
	localparam logic [MUL_W-1:0]   MULTIPLIER      = 15'd18782;
	localparam logic [WORD_W-1:0]  COMPLEMENT_BASE = 32'hffff_fffe;
	localparam logic [IDX_W-1:0]   INDEX_RESET     = IDX_W'(TABLE_DEPTH - 1);
	localparam logic [IDX_W-1:0]   INDEX_LAST      = IDX_W'(TABLE_DEPTH - 1);

	typedef enum logic [0:0] {
		OP_DRAW   = 1'b0,
		OP_RESEED = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FILL,
		ST_READ,
		ST_MUL,
		ST_ADD,
		ST_FIX
	} state_t;

endpackage

>>> design/cmwc_ram.sv
// ----------------------------------------------------------------------------
// cmwc_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module cmwc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> design/cmwc_random_generator_top.sv
// ----------------------------------------------------------------------------
// cmwc_random_generator_top
// Complementary multiply-with-carry (CMWC4096) pseudo-random word generator.
// ----------------------------------------------------------------------------
// The block takes one transaction at a time and returns one 32-bit word per
// transaction. A draw loads its word into the output register through the
// read of the lag word from the 4096-entry table RAM, the multiply by 18782,
// the carry add, and the overflow fix with write-back. The next transaction
// is taken in the idle state that follows, so a draw is not accepted before
// the last one has left the fix step. A reseed transaction first refills the
// whole table, one word per cycle through the single RAM write port, and then
// draws. The carry and table index survive a reseed. The table content is
// undefined after reset; reseed before the first draw. A finished word waits
// in an output register, so the next transaction is accepted while the
// previous result is still stalled. That transaction then waits in the fix
// step until the output register is free.
module cmwc_random_generator_top
	import cmwc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              operation,
	input  logic [WORD_W-1:0] seed,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [WORD_W-1:0] random_word
);

	state_t state_q, state_d;

	logic [IDX_W-1:0]   fill_cnt_q;
	logic [IDX_W-1:0]   idx_q;
	logic [CARRY_W-1:0] carry_q;
	logic [WORD_W-1:0]  seed_q;
	logic [WORD_W-1:0]  hist0_q, hist1_q, hist2_q;
	logic [PROD_W-1:0]  prod_s1;
	logic [SUM_W-1:0]   sum_s2;
	logic               out_valid_q;
	logic [WORD_W-1:0]  random_word_q;

	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	logic [WORD_W-1:0]  ram_wdata;
	logic [WORD_W-1:0]  ram_rdata;

	logic               accept;
	logic               fill_last;
	logic               idx_adv;
	logic               load_out;
	logic [WORD_W-1:0]  fill_word;

	logic [CHI_W-1:0]   c_raw;
	logic [WORD_W:0]    x_sum;
	logic               wrap;
	logic [WORD_W-1:0]  x_fix;
	logic [CHI_W-1:0]   c_new;
	logic [WORD_W-1:0]  result;

	assign accept    = in_valid && !in_stall;
	assign fill_last = (fill_cnt_q == INDEX_LAST);

	// generate the next fill word from the seed, later from the third and second last words
	always_comb begin
		priority if (fill_cnt_q == IDX_W'(0)) begin
			fill_word = seed_q;
		end else if (fill_cnt_q == IDX_W'(1)) begin
			fill_word = seed_q + PHI_WORD;
		end else if (fill_cnt_q == IDX_W'(2)) begin
			fill_word = seed_q + PHI_WORD_X2;
		end else begin
			fill_word = hist2_q ^ hist1_q ^ PHI_WORD ^ WORD_W'(fill_cnt_q);
		end
	end

	// fold the carry back in and complement
	assign c_raw  = sum_s2[SUM_W-1:WORD_W];
	assign x_sum  = {1'b0, sum_s2[WORD_W-1:0]} + (WORD_W+1)'(c_raw);
	assign wrap   = x_sum[WORD_W];
	assign x_fix  = x_sum[WORD_W-1:0] + WORD_W'(wrap);
	assign c_new  = c_raw + CHI_W'(wrap);
	assign result = COMPLEMENT_BASE - x_fix;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and control
	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = result;
		load_out  = 1'b0;
		idx_adv   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (op_t'(operation) == OP_RESEED) begin
						state_d = ST_FILL;
					end else begin
						state_d = ST_READ;
						idx_adv = 1'b1;
					end
				end
			end
			ST_FILL: begin
				ram_we    = 1'b1;
				ram_waddr = fill_cnt_q;
				ram_wdata = fill_word;
				if (fill_last) begin
					state_d = ST_READ;
					idx_adv = 1'b1;
				end
			end
			ST_READ: begin
				state_d = ST_MUL;
			end
			ST_MUL: begin
				state_d = ST_ADD;
			end
			ST_ADD: begin
				state_d = ST_FIX;
			end
			ST_FIX: begin
				if (!out_valid_q || !out_stall) begin
					ram_we   = 1'b1;
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// index, carry and fill counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= INDEX_RESET;
			carry_q    <= CARRY_RESET;
			fill_cnt_q <= '0;
		end else begin
			if (idx_adv) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (load_out) begin
				carry_q <= CARRY_W'(c_new);
			end
			if (accept) begin
				fill_cnt_q <= '0;
			end else if (state_q == ST_FILL) begin
				fill_cnt_q <= fill_cnt_q + IDX_W'(1);
			end
		end
	end

	// seed capture, fill history and arithmetic stages
	always_ff @(posedge clk) begin
		if (accept) begin
			seed_q <= seed;
		end
		if (state_q == ST_FILL) begin
			hist2_q <= hist1_q;
			hist1_q <= hist0_q;
			hist0_q <= fill_word;
		end
		if (state_q == ST_MUL) begin
			prod_s1 <= PROD_W'(MULTIPLIER) * PROD_W'(ram_rdata);
		end
		if (state_q == ST_ADD) begin
			sum_s2 <= SUM_W'(prod_s1) + SUM_W'(carry_q);
		end
	end

	// output register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			random_word_q <= result;
		end
	end

	assign out_valid   = out_valid_q;
	assign random_word = random_word_q;

	// lag table
	cmwc_ram #(
		.WIDTH (WORD_W),
		.DEPTH (TABLE_DEPTH)
	) u_lag_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

endmodule

>>> design/cmwc_checker.sv
// ----------------------------------------------------------------------------
// cmwc_checker
// Port-level checks of the CMWC4096 generator, bound to the top level.
// ----------------------------------------------------------------------------
module cmwc_checker
	import cmwc_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              operation,
	input logic              out_valid,
	input logic              out_stall,
	input logic [WORD_W-1:0] random_word
);

	logic in_accept;

	assign in_accept = in_valid && !in_stall;

	// a transaction keeps the block busy through read, multiply and add
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> in_stall ##1 in_stall ##1 in_stall)
		else $error("input accepted too soon after a transaction");

	// a reseed stalls the input and raises no result at the single point sampled during the table fill
	a_reseed_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && op_t'(operation) == OP_RESEED) |=> in_stall ##5 !out_valid
			|| !$rose(out_valid))
		else $error("reseed result appeared before table fill");

	// a new result appears only while the block is working
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared while block was idle");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(random_word)))
		else $error("stalled result changed");

endmodule

bind cmwc_random_generator_top cmwc_checker u_cmwc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.operation   (operation),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.random_word (random_word)
);
